FILE: sv/utfseg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfseg_pkg
// Shared types and fixed widths for the UTF-8 codepoint segmenter.
// ----------------------------------------------------------------------------
package utfseg_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 3;
  localparam int COUNT_W = 17;
  localparam int BEATS_W = 3;
  localparam int START_W = 16;

  // One input beat: a raw byte and the end-of-buffer flag.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  // One group of result beats caused by a single input byte.
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [BEATS_W-1:0] beats;
    logic [COUNT_W-1:0] count;
    logic               last;
  } bundle_t;

endpackage : utfseg_pkg
`default_nettype wire

FILE: sv/utfseg_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfseg_skid
// Input skid register, so that the input stall comes straight from a flop.
// ----------------------------------------------------------------------------
module utfseg_skid
  import utfseg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  input  logic  consume,
  output logic  in_stall,
  output logic  head_valid,
  output item_t head
);

  logic  skid_v_r;
  logic  skid_v_nxt;
  item_t skid_r;

  assign in_stall   = skid_v_r;
  assign head_valid = skid_v_r | in_valid;
  assign head       = skid_v_r ? skid_r : in_item;

  // A beat that arrives while the tracker cannot take it is parked here.
  always_comb begin
    if (skid_v_r) begin
      skid_v_nxt = ~consume;
    end else begin
      skid_v_nxt = in_valid & ~consume;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= in_item;
    end
  end

endmodule : utfseg_skid
`default_nettype wire

FILE: sv/utfseg_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfseg_track
// Sequence tracker: holds the pending sequence and buffer position, and turns
// each byte into a run of result beats for the emitter.
// ----------------------------------------------------------------------------
module utfseg_track
  import utfseg_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 65536,
  localparam int POS_W = $clog2(MAX_BUFFER_BYTES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  item_t            head,
  input  logic             can_load,
  output logic             consume,
  output logic             load,
  output bundle_t          bundle,
  output logic [POS_W-1:0] bundle_start
);

  localparam int COUNT_CAP = (MAX_BUFFER_BYTES > 131071) ? 131071 : MAX_BUFFER_BYTES;
  localparam logic [COUNT_W:0] CAP_X = (COUNT_W+1)'(COUNT_CAP);
  localparam logic [POS_W:0]   WRAP  = (POS_W+1)'(MAX_BUFFER_BYTES);

  logic [LEN_W-1:0]   exp_r,    exp_nxt;
  logic [1:0]         held_r,   held_nxt;
  logic [POS_W-1:0]   pstart_r, pstart_nxt;
  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [COUNT_W-1:0] total_r,  total_nxt;

  logic [LEN_W-1:0]   lead_len;
  logic               is_cont;
  logic               pend;
  logic [LEN_W-1:0]   held_inc;
  logic [LEN_W-1:0]   held_ext;
  logic [BEATS_W-1:0] n_beats;
  logic               full;
  logic [POS_W-1:0]   base;
  logic [COUNT_W:0]   sum_n;
  logic [COUNT_W:0]   sum_1;
  logic [POS_W:0]     pos_inc;

  always_comb begin
    if (head.data[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (head.data[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (head.data[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  assign is_cont  = (head.data[7:6] == 2'b10);
  assign pend     = (exp_r != 3'd0);
  assign held_ext = {1'b0, held_r};
  assign held_inc = held_ext + 3'd1;

  // Flushed bytes always sit at consecutive offsets ending at or just before
  // the current byte, so every run of 1-byte results is a base plus a count.
  always_comb begin
    exp_nxt    = exp_r;
    held_nxt   = held_r;
    pstart_nxt = pstart_r;
    n_beats    = 3'd0;
    full       = 1'b0;
    base       = pos_r;
    if (pend && is_cont) begin
      base = pstart_r;
      if (held_inc >= exp_r) begin
        exp_nxt  = 3'd0;
        held_nxt = 2'd0;
        n_beats  = 3'd1;
        full     = 1'b1;
      end else if (head.last) begin
        exp_nxt  = 3'd0;
        held_nxt = 2'd0;
        n_beats  = held_inc;
      end else begin
        held_nxt = held_inc[1:0];
      end
    end else begin
      if (pend) begin
        base = pstart_r;
      end
      if ((lead_len != 3'd0) && !head.last) begin
        exp_nxt    = lead_len;
        held_nxt   = 2'd1;
        pstart_nxt = pos_r;
        n_beats    = pend ? held_ext : 3'd0;
      end else begin
        exp_nxt  = 3'd0;
        held_nxt = 2'd0;
        n_beats  = (pend ? held_ext : 3'd0) + 3'd1;
      end
    end
  end

  assign consume = head_valid & ((n_beats == 3'd0) | can_load);
  assign load    = consume & (n_beats != 3'd0);

  assign sum_n = {1'b0, total_r} + (COUNT_W+1)'(n_beats);
  assign sum_1 = {1'b0, total_r} + (COUNT_W+1)'(1);

  always_comb begin
    if (head.last) begin
      total_nxt = '0;
    end else if (sum_n > CAP_X) begin
      total_nxt = CAP_X[COUNT_W-1:0];
    end else begin
      total_nxt = sum_n[COUNT_W-1:0];
    end
  end

  assign pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);

  always_comb begin
    if (head.last || (pos_inc >= WRAP)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[POS_W-1:0];
    end
  end

  assign bundle.len   = full ? exp_r : 3'd1;
  assign bundle.beats = n_beats;
  assign bundle.count = (sum_1 > CAP_X) ? CAP_X[COUNT_W-1:0] : sum_1[COUNT_W-1:0];
  assign bundle.last  = head.last;
  assign bundle_start = base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r    <= '0;
      held_r   <= '0;
      pstart_r <= '0;
      pos_r    <= '0;
      total_r  <= '0;
    end else if (consume) begin
      exp_r    <= exp_nxt;
      held_r   <= held_nxt;
      pstart_r <= pstart_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule : utfseg_track
`default_nettype wire

FILE: sv/utfseg_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfseg_emit
// Result register: holds one run of result beats and steps through it, one
// beat per cycle unless stalled, advancing the offset and the running count.
// ----------------------------------------------------------------------------
module utfseg_emit
  import utfseg_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 65536,
  localparam int POS_W = $clog2(MAX_BUFFER_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bundle_t            bundle,
  input  logic [POS_W-1:0]   bundle_start,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [START_W-1:0] out_seg_start,
  output logic [LEN_W-1:0]   out_seg_len,
  output logic [COUNT_W-1:0] out_codepoint_count,
  output logic               out_run_last,
  output logic               out_buffer_done
);

  localparam int COUNT_CAP = (MAX_BUFFER_BYTES > 131071) ? 131071 : MAX_BUFFER_BYTES;
  localparam logic [COUNT_W:0] CAP_X = (COUNT_W+1)'(COUNT_CAP);
  localparam logic [POS_W:0]   WRAP  = (POS_W+1)'(MAX_BUFFER_BYTES);
  localparam int EXT_W = (POS_W > START_W) ? POS_W : START_W;

  logic               bv_r;
  logic [POS_W-1:0]   start_r;
  logic [LEN_W-1:0]   len_r;
  logic [BEATS_W-1:0] beats_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r;

  logic               adv;
  logic               fin;
  logic [POS_W:0]     start_inc;
  logic [POS_W-1:0]   start_nxt;
  logic [COUNT_W:0]   count_inc;
  logic [COUNT_W-1:0] count_nxt;
  logic [EXT_W-1:0]   start_ext;

  assign adv      = bv_r & ~out_stall;
  assign fin      = adv & (beats_r == 3'd1);
  assign can_load = ~bv_r | fin;

  assign start_inc = {1'b0, start_r} + (POS_W+1)'(1);
  assign start_nxt = (start_inc >= WRAP) ? '0 : start_inc[POS_W-1:0];
  assign count_inc = {1'b0, count_r} + (COUNT_W+1)'(1);
  assign count_nxt = (count_inc > CAP_X) ? CAP_X[COUNT_W-1:0] : count_inc[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else if (load) begin
      bv_r <= 1'b1;
    end else if (fin) begin
      bv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= bundle_start;
      len_r   <= bundle.len;
      beats_r <= bundle.beats;
      count_r <= bundle.count;
      last_r  <= bundle.last;
    end else if (adv) begin
      start_r <= start_nxt;
      beats_r <= beats_r - 3'd1;
      count_r <= count_nxt;
    end
  end

  assign start_ext           = EXT_W'(start_r);
  assign out_valid           = bv_r;
  assign out_seg_start       = start_ext[START_W-1:0];
  assign out_seg_len         = len_r;
  assign out_codepoint_count = count_r;
  assign out_run_last        = (beats_r == 3'd1);
  assign out_buffer_done     = last_r & (beats_r == 3'd1);

endmodule : utfseg_emit
`default_nettype wire

FILE: sv/utf8_codepoint_segmenter.sv
`default_nettype none
// The first result of a byte is registered, loaded when the tracker takes it.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is not stalled; a byte that flushes a broken sequence gives k
// results, which the single result register steps through one at a time.
// Reset: synchronous, active low; the control state clears, no sweep.
// ----------------------------------------------------------------------------
// utf8_codepoint_segmenter
// Splits a byte stream into UTF-8 codepoint segments with offsets and counts.
// ----------------------------------------------------------------------------
module utf8_codepoint_segmenter
  import utfseg_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [START_W-1:0] out_seg_start,
  output logic [LEN_W-1:0]   out_seg_len,
  output logic [COUNT_W-1:0] out_codepoint_count,
  output logic               out_run_last,
  output logic               out_buffer_done
);

  localparam int POS_W = $clog2(MAX_BUFFER_BYTES);

  // The input beat, as seen by the tracker: either straight from the port or
  // from the skid register when the previous beat could not be taken.
  item_t            in_item;
  item_t            head;
  logic             head_valid;

  // The tracker takes a byte when the result register is free or is handing
  // over its final beat in this cycle; a byte with no results always goes.
  logic             consume;
  logic             load;
  logic             can_load;
  bundle_t          bundle;
  logic [POS_W-1:0] bundle_start;

  assign in_item.data = in_data_byte;
  assign in_item.last = in_end_of_buffer;

  utfseg_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .consume    (consume),
    .in_stall   (in_stall),
    .head_valid (head_valid),
    .head       (head)
  );

  // The tracker holds the pending sequence, the byte offset and the count,
  // and decides in one pass how many results the byte causes. All of them are
  // either one full codepoint or a run of 1-byte segments at consecutive
  // offsets, so a start, a length and a beat count describe the whole run.
  utfseg_track #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .can_load     (can_load),
    .consume      (consume),
    .load         (load),
    .bundle       (bundle),
    .bundle_start (bundle_start)
  );

  // The emitter is the result register. It walks through the run one beat at
  // a time, stepping the offset with wrap and the count with saturation.
  utfseg_emit #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (load),
    .bundle              (bundle),
    .bundle_start        (bundle_start),
    .can_load            (can_load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_seg_start       (out_seg_start),
    .out_seg_len         (out_seg_len),
    .out_codepoint_count (out_codepoint_count),
    .out_run_last        (out_run_last),
    .out_buffer_done     (out_buffer_done)
  );

endmodule : utf8_codepoint_segmenter
`default_nettype wire

FILE: sv/utfseg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utfseg_checker
// Port-level checks for the UTF-8 codepoint segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module utfseg_checker
  import utfseg_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [START_W-1:0] out_seg_start,
  input logic [LEN_W-1:0]   out_seg_len,
  input logic [COUNT_W-1:0] out_codepoint_count,
  input logic               out_run_last,
  input logic               out_buffer_done
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seg_start) &&
    $stable(out_seg_len) && $stable(out_codepoint_count))
    else $error("stalled result beat changed");

  // Straight after reset nothing is pending on either side.
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // The end of a buffer always closes a byte's run of results.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_buffer_done |-> out_run_last)
    else $error("buffer done without run last");

  // A full multi-byte codepoint is always the only result of its byte.
  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_seg_len != 3'd1) |-> out_run_last && (out_codepoint_count != '0))
    else $error("multi-byte segment not alone");

  // A run of flushed bytes is delivered without a gap.
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("gap inside a run of results");

endmodule : utfseg_checker

bind utf8_codepoint_segmenter utfseg_checker u_checker (.*);
`default_nettype wire
